// ===== sv/scmmd_pkg.sv =====
// shared types and constants for the scope column min/max decimator
// no dependencies; imported by the mapping pipeline and the top level

package scmmd_pkg;

	// fixed field widths
	localparam int IDX_W      = 24;
	localparam int XB_W       = 12;
	localparam int XR_W       = 32;
	localparam int XP_W       = 18;
	localparam int YB_W       = 16;
	localparam int YG_W       = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// column arithmetic widths
	localparam int T_W = 42;
	localparam int M_W = 41;
	localparam int A_W = 57;
	localparam int B_W = 49;
	localparam int L_W = 50;
	localparam int Q_W = 42;
	localparam int V_W = 44;

	// rounding term, one half in the 2^32 scaled product
	localparam logic [B_W-1:0] ROUND_HALF = 49'h0_0000_8000_0000;

	// mapping pipeline depth and output queue
	localparam int MAP_STAGES = 6;
	localparam int OUT_DEPTH  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_BASE  = 3'd0,
		REG_X_LIMIT = 3'd1,
		REG_X_RATIO = 3'd2,
		REG_X_PHASE = 3'd3,
		REG_Y_BASE  = 3'd4,
		REG_Y_GAIN  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [XB_W-1:0] x_base;
		logic [XB_W-1:0] x_limit;
		logic [XR_W-1:0] x_ratio;
		logic [XP_W-1:0] x_phase;
		logic [YB_W-1:0] y_base;
		logic [YG_W-1:0] y_gain;
	} cfg_t;

	localparam logic [XB_W-1:0] X_BASE_RST  = 12'h000;
	localparam logic [XB_W-1:0] X_LIMIT_RST = 12'hFFF;
	localparam logic [XR_W-1:0] X_RATIO_RST = 32'h0001_0000;
	localparam logic [XP_W-1:0] X_PHASE_RST = 18'h0_0000;
	localparam logic [YB_W-1:0] Y_BASE_RST  = 16'h0000;
	localparam logic [YG_W-1:0] Y_GAIN_RST  = 24'h01_0000;

endpackage

// ===== sv/scmmd_map.sv =====
// six stage pipeline mapping sample index to screen column and sample to row
// depends on scmmd_pkg

module scmmd_map
	import scmmd_pkg::*;
#(
	parameter int COLUMN_BITS = 12,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          in_valid,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic [IDX_W-1:0]              in_index,
	input  logic                          in_start,
	output logic                          out_valid,
	output logic                          out_start,
	output logic [COLUMN_BITS-1:0]        out_col,
	output logic signed [SAMPLE_BITS-1:0] out_row,
	output logic [MAP_STAGES-1:0]         busy
);

	localparam int CB   = COLUMN_BITS;
	localparam int SB   = SAMPLE_BITS;
	localparam int YP_W = SB + YG_W;
	localparam int D_W  = SB + 8;
	localparam int RW   = SB + 10;
	localparam logic signed [RW-1:0] ROW_MAX = RW'((1 << (SB - 1)) - 1);
	localparam logic signed [RW-1:0] ROW_MIN = ~ROW_MAX;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic bs_s1, bs_s2, bs_s3, bs_s4, bs_s5, bs_s6;

	logic signed [SB-1:0]  sample_s1;
	logic [IDX_W-1:0]      index_s1;
	logic signed [T_W-1:0] t_s2;
	logic                  sneg_s2;
	logic [SB-1:0]         smag_s2;
	logic [M_W-1:0]        m_s3;
	logic                  neg_s3, sneg_s3;
	logic [YP_W-1:0]       yprod_s3;
	logic [A_W-1:0]        a_s4;
	logic [B_W-1:0]        b_s4;
	logic                  neg_s4;
	logic signed [D_W:0]   yd_s4;
	logic [Q_W-1:0]        q_s5;
	logic                  neg_s5;
	logic signed [RW-1:0]  rowraw_s5;
	logic [CB-1:0]         col_s6;
	logic signed [SB-1:0]  row_s6;

	logic signed [T_W-1:0] t_c;
	logic [SB-1:0]         smag_c;
	logic [M_W-1:0]        m_c;
	logic [YP_W-1:0]       yprod_c;
	logic [A_W-1:0]        a_c;
	logic [B_W-1:0]        b_c;
	logic [D_W-1:0]        d_c;
	logic signed [D_W:0]   yd_c;
	logic [L_W-1:0]        low_c;
	logic [Q_W-1:0]        q_c;
	logic signed [RW-1:0]  rowraw_c;
	logic [V_W-1:0]        xb_c, v_c;
	logic [CB-1:0]         col_c;
	logic signed [SB-1:0]  row_c;

	always_comb begin
		// index in Q16 plus phase
		t_c = $signed({2'b00, index_s1, 16'h0000})
			+ $signed({{(T_W-XP_W){cfg.x_phase[XP_W-1]}}, cfg.x_phase});
		smag_c = sample_s1[SB-1] ? SB'(-sample_s1) : SB'(sample_s1);

		m_c = t_s2[T_W-1] ? M_W'(-t_s2) : t_s2[M_W-1:0];
		yprod_c = YP_W'(smag_s2) * YP_W'(cfg.y_gain);

		a_c = A_W'(m_s3[M_W-1:16]) * A_W'(cfg.x_ratio);
		b_c = B_W'(m_s3[15:0]) * B_W'(cfg.x_ratio) + ROUND_HALF;
		d_c = yprod_s3[YP_W-1:16];
		yd_c = sneg_s3 ? -$signed({1'b0, d_c}) : $signed({1'b0, d_c});

		low_c = L_W'({a_s4[15:0], 16'h0000}) + L_W'(b_s4);
		q_c = Q_W'(a_s4[A_W-1:16]) + Q_W'(low_c[L_W-1:32]);
		rowraw_c = $signed({{(RW-YB_W){cfg.y_base[YB_W-1]}}, cfg.y_base})
			- $signed({yd_s4[D_W], yd_s4});

		// column offset, negative positions step back q - 1 columns
		xb_c = V_W'(cfg.x_base);
		if (!neg_s5) begin
			v_c = xb_c + V_W'(q_s5);
		end else if (q_s5 == '0) begin
			v_c = xb_c;
		end else begin
			v_c = xb_c + V_W'(1) - V_W'(q_s5);
		end
		if (v_c[V_W-1]) begin
			col_c = '0;
		end else if (|v_c[V_W-2:CB]) begin
			col_c = '1;
		end else begin
			col_c = v_c[CB-1:0];
		end

		if (rowraw_s5 > ROW_MAX) begin
			row_c = ROW_MAX[SB-1:0];
		end else if (rowraw_s5 < ROW_MIN) begin
			row_c = ROW_MIN[SB-1:0];
		end else begin
			row_c = rowraw_s5[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			sample_s1 <= in_sample;
			index_s1  <= in_index;
			bs_s1     <= in_start;
		end
		t_s2      <= t_c;
		sneg_s2   <= sample_s1[SB-1];
		smag_s2   <= smag_c;
		bs_s2     <= bs_s1;
		m_s3      <= m_c;
		neg_s3    <= t_s2[T_W-1];
		sneg_s3   <= sneg_s2;
		yprod_s3  <= yprod_c;
		bs_s3     <= bs_s2;
		a_s4      <= a_c;
		b_s4      <= b_c;
		neg_s4    <= neg_s3;
		yd_s4     <= yd_c;
		bs_s4     <= bs_s3;
		q_s5      <= q_c;
		neg_s5    <= neg_s4;
		rowraw_s5 <= rowraw_c;
		bs_s5     <= bs_s4;
		col_s6    <= col_c;
		row_s6    <= row_c;
		bs_s6     <= bs_s5;
	end

	assign out_valid = v_s6;
	assign out_start = bs_s6;
	assign out_col   = col_s6;
	assign out_row   = row_s6;
	assign busy      = {v_s6, v_s5, v_s4, v_s3, v_s2, v_s1};

endmodule

// ===== sv/scmmd_fifo.sv =====
// small result queue taking up to two items per cycle and giving one
// no dependencies; used by the top level

module scmmd_fifo #(
	parameter int WIDTH = 29,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push0,
	input  logic                     push1,
	input  logic [WIDTH-1:0]         din0,
	input  logic [WIDTH-1:0]         din1,
	input  logic                     pop,
	output logic [WIDTH-1:0]         dout,
	output logic [$clog2(DEPTH):0]   count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = PW + 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_q] <= din0;
		end
		if (push1) begin
			mem_q[wr_q + PW'(1)] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push0) + PW'(push1);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + CW'(push0) + CW'(push1) - CW'(pop);
		end
	end

	assign dout  = mem_q[rd_q];
	assign count = cnt_q;

endmodule

// ===== sv/scope_column_minmax_decimator_unit.sv =====
// top level of the scope column min/max decimator: config registers,
// pending column state and output handshake; uses scmmd_pkg, scmmd_map, scmmd_fifo
//
// usage:
//   s_tdata carries one sample and its sweep index, s_tuser flags the first
//   sample of a block. each item maps to a screen column and row; samples in
//   the same column only update that column's min and max row. when an item
//   lands in a new column, the pending column goes out on m_tdata as its min
//   point and, if different, its max point; m_tlast marks the final point
//   caused by that item.
//   points of an item go out on m_tdata after it passes the six mapping
//   stages and then the queue register that the last stage feeds.
//   throughput: one item per cycle while s_tready is high; two points need
//   two output transfers. s_tready is low whenever the 16 entry result queue
//   could not take the worst case of two points for every item in the mapping
//   pipeline, so a stalled receiver backs up into s_tready after a few items.
//   reset clears the pending column, stop flag, queue and config registers
//   (x_limit 4095, x_ratio and y_gain 1.0, others 0).
//   cfg_we writes register cfg_index; write only while idle.

module scope_column_minmax_decimator_unit
	import scmmd_pkg::*;
#(
	parameter int COLUMN_BITS = 12,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           s_tvalid,
	output logic                                           s_tready,
	// sample, sample_index
	input  logic [((SAMPLE_BITS+IDX_W+7)/8)*8-1:0]         s_tdata,
	// block_start
	input  logic                                           s_tuser,
	output logic                                           m_tvalid,
	input  logic                                           m_tready,
	// point_x, point_y
	output logic [((COLUMN_BITS+SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,
	// last_point
	output logic                                           m_tlast,
	input  logic                                           cfg_we,
	input  logic [CFG_IDX_W-1:0]                           cfg_index,
	input  logic [CFG_DATA_W-1:0]                          cfg_data
);

	localparam int CB       = COLUMN_BITS;
	localparam int SB       = SAMPLE_BITS;
	localparam int M_DATA_W = ((CB + SB + 7) / 8) * 8;
	localparam int ENT_W    = CB + SB + 1;
	localparam int CNT_W    = $clog2(OUT_DEPTH) + 1;
	localparam int NEED_W   = CNT_W + 2;
	localparam int BUSY_W   = $clog2(MAP_STAGES + 1);

	cfg_t cfg_q;

	logic                   accept;
	logic                   map_valid, map_start;
	logic [CB-1:0]          map_col;
	logic signed [SB-1:0]   map_row;
	logic [MAP_STAGES-1:0]  busy;
	logic [BUSY_W-1:0]      busy_cnt;
	logic [NEED_W-1:0]      need;

	logic                   pv_q, stop_q;
	logic [CB-1:0]          pcol_q;
	logic signed [SB-1:0]   cmin_q, cmax_q;
	logic                   pv_n, stop_n, pv_eff, proc, over;
	logic [CB-1:0]          pcol_n;
	logic signed [SB-1:0]   cmin_n, cmax_n;

	logic                   push0, push1, pop;
	logic [ENT_W-1:0]       ent0, ent1, head;
	logic [CNT_W-1:0]       out_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_base  <= X_BASE_RST;
			cfg_q.x_limit <= X_LIMIT_RST;
			cfg_q.x_ratio <= X_RATIO_RST;
			cfg_q.x_phase <= X_PHASE_RST;
			cfg_q.y_base  <= Y_BASE_RST;
			cfg_q.y_gain  <= Y_GAIN_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_X_BASE:  cfg_q.x_base  <= cfg_data[XB_W-1:0];
				REG_X_LIMIT: cfg_q.x_limit <= cfg_data[XB_W-1:0];
				REG_X_RATIO: cfg_q.x_ratio <= cfg_data[XR_W-1:0];
				REG_X_PHASE: cfg_q.x_phase <= cfg_data[XP_W-1:0];
				REG_Y_BASE:  cfg_q.y_base  <= cfg_data[YB_W-1:0];
				REG_Y_GAIN:  cfg_q.y_gain  <= cfg_data[YG_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = s_tvalid & s_tready;

	scmmd_map #(
		.COLUMN_BITS(CB),
		.SAMPLE_BITS(SB)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (accept),
		.in_sample (s_tdata[SB-1:0]),
		.in_index  (s_tdata[SB+IDX_W-1:SB]),
		.in_start  (s_tuser),
		.out_valid (map_valid),
		.out_start (map_start),
		.out_col   (map_col),
		.out_row   (map_row),
		.busy      (busy)
	);

	// room for two points per item in flight plus the new one
	always_comb begin
		busy_cnt = '0;
		for (int i = 0; i < MAP_STAGES; i++) begin
			busy_cnt = busy_cnt + BUSY_W'(busy[i]);
		end
		need = NEED_W'(out_cnt) + NEED_W'({busy_cnt, 1'b0}) + NEED_W'(2);
	end

	assign s_tready = (need <= NEED_W'(OUT_DEPTH));

	always_comb begin
		pv_n   = pv_q;
		stop_n = stop_q;
		pcol_n = pcol_q;
		cmin_n = cmin_q;
		cmax_n = cmax_q;
		push0  = 1'b0;
		push1  = 1'b0;
		proc   = 1'b0;
		pv_eff = pv_q;
		over   = ({1'b0, 16'(pcol_q)} > {5'b0, cfg_q.x_limit});
		ent0   = {cmin_q == cmax_q, cmin_q, pcol_q};
		ent1   = {1'b1, cmax_q, pcol_q};
		if (map_valid) begin
			if (map_start) begin
				stop_n = 1'b0;
				pv_eff = 1'b0;
				proc   = 1'b1;
			end else if (!stop_q) begin
				if (pv_q && over) begin
					stop_n = 1'b1;
				end else begin
					proc = 1'b1;
				end
			end
		end
		if (proc) begin
			if (pv_eff && map_col == pcol_q) begin
				if (map_row < cmin_q) begin
					cmin_n = map_row;
				end
				if (map_row > cmax_q) begin
					cmax_n = map_row;
				end
			end else begin
				push0  = pv_eff;
				push1  = pv_eff && (cmin_q != cmax_q);
				pv_n   = 1'b1;
				pcol_n = map_col;
				cmin_n = map_row;
				cmax_n = map_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= 1'b0;
			stop_q <= 1'b0;
			pcol_q <= '0;
			cmin_q <= '0;
			cmax_q <= '0;
		end else begin
			pv_q   <= pv_n;
			stop_q <= stop_n;
			pcol_q <= pcol_n;
			cmin_q <= cmin_n;
			cmax_q <= cmax_n;
		end
	end

	scmmd_fifo #(
		.WIDTH(ENT_W),
		.DEPTH(OUT_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (push0),
		.push1  (push1),
		.din0   (ent0),
		.din1   (ent1),
		.pop    (pop),
		.dout   (head),
		.count  (out_cnt)
	);

	assign m_tvalid = (out_cnt != '0);
	assign pop      = m_tvalid & m_tready;
	assign m_tdata  = M_DATA_W'(head[CB+SB-1:0]);
	assign m_tlast  = head[ENT_W-1];

endmodule

// ===== sv/scmmd_chk.sv =====
// port level checks on the decimator output stream, bound to the top level
// depends on scope_column_minmax_decimator_unit

module scmmd_chk #(
	parameter int COLUMN_BITS = 12,
	parameter int SAMPLE_BITS = 16
) (
	input logic                                          clk,
	input logic                                          arst_n,
	input logic                                          m_tvalid,
	input logic                                          m_tready,
	input logic [((COLUMN_BITS+SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,
	input logic                                          m_tlast
);

	localparam int CB = COLUMN_BITS;
	localparam int SB = SAMPLE_BITS;

	// queue comes out of reset empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

	// a min point without tlast always has its max point queued behind it
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("max point missing after min point");

	// second point of a pair is the same column with a strictly larger row
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tdata[CB-1:0] == $past(m_tdata[CB-1:0]) &&
			$signed(m_tdata[CB+SB-1:CB]) > $signed($past(m_tdata[CB+SB-1:CB])))
		else $error("pair column or row order wrong");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

endmodule

bind scope_column_minmax_decimator_unit scmmd_chk #(
	.COLUMN_BITS(COLUMN_BITS),
	.SAMPLE_BITS(SAMPLE_BITS)
) u_scmmd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// testbench for scope_column_minmax_decimator_unit: sends sample items with random gaps and
// stalls, predicts each screen column's min/max points and checks them in order
// depends on scmmd_pkg and the rtl of the unit

module tb_top
	import scmmd_pkg::*;
;

	localparam int LATENCY = 6;
	localparam longint COL_MAX = (1 << XB_W) - 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

	typedef struct packed {
		logic [XB_W-1:0]        x;
		logic signed [YB_W-1:0] y;
		logic                   last;
	} point_t;

	logic clk;
	logic arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [39:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast;
	logic [31:0] m_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cfg_t cfg;
	logic pend_valid, sweep_stopped;
	logic [XB_W-1:0] pend_col;
	logic signed [YB_W-1:0] col_min, col_max;
	point_t points_due[$];
	int mismatch_count = 0;
	int items_sent = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_hold = 0;

	scope_column_minmax_decimator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [XB_W-1:0] column_of(logic [23:0] idx);
		longint t, q, off, col;
		logic [63:0] mag;
		logic [127:0] prod;
		t = longint'(idx) * 65536 + longint'($signed(cfg.x_phase));
		mag = (t < 0) ? -t : t;
		prod = 128'(mag) * 128'(cfg.x_ratio) + (128'd1 << 31);
		q = longint'(prod[95:32]);
		if (t >= 0)
			off = q;
		else
			off = (q >= 1) ? 1 - q : 0;
		col = longint'(cfg.x_base) + off;
		if (col < 0)
			col = 0;
		else if (col > COL_MAX)
			col = COL_MAX;
		return col[XB_W-1:0];
	endfunction

	function automatic logic signed [YB_W-1:0] row_of(logic signed [15:0] smp);
		longint s, mag, d, r;
		s = smp;
		mag = (s < 0) ? -s : s;
		d = (mag * longint'(cfg.y_gain)) >>> 16;
		if (s < 0)
			d = -d;
		r = longint'($signed(cfg.y_base)) - d;
		if (r < -32768)
			r = -32768;
		else if (r > 32767)
			r = 32767;
		return r[YB_W-1:0];
	endfunction

	function automatic void decimate_item(logic signed [15:0] smp, logic [23:0] idx, logic start);
		logic [XB_W-1:0] col;
		logic signed [YB_W-1:0] row;
		if (start) begin
			pend_valid = 1'b0;
			sweep_stopped = 1'b0;
		end else begin
			if (sweep_stopped)
				return;
			if (pend_valid && pend_col > cfg.x_limit) begin
				sweep_stopped = 1'b1;
				return;
			end
		end
		col = column_of(idx);
		row = row_of(smp);
		if (pend_valid && col == pend_col) begin
			if (row < col_min)
				col_min = row;
			if (row > col_max)
				col_max = row;
			return;
		end
		if (pend_valid) begin
			points_due.push_back('{x: pend_col, y: col_min, last: col_min == col_max});
			if (col_min != col_max)
				points_due.push_back('{x: pend_col, y: col_max, last: 1'b1});
		end
		pend_valid = 1'b1;
		pend_col = col;
		col_min = row;
		col_max = row;
	endfunction

	function automatic void note_mismatch(string msg);
		if (mismatch_count < 10)
			$display("mismatch: %s", msg);
		mismatch_count++;
	endfunction

	always @(posedge clk) begin : check_points
		point_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.x = m_tdata[11:0];
			got.y = m_tdata[27:12];
			got.last = m_tlast;
			if (points_due.size() == 0) begin
				note_mismatch($sformatf("unexpected point x=%0d y=%0d last=%0b",
					got.x, $signed(got.y), got.last));
			end else begin
				want = points_due.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.last !== want.last)
					note_mismatch($sformatf("expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
						want.x, $signed(want.y), want.last, got.x, $signed(got.y), got.last));
			end
		end
	end

	initial begin : receiver
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = rx_idle ? $urandom_range(0, 16) : 0;
			if (rx_hold > 0) begin
				gap = rx_hold;
				rx_hold = 0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic send_sample(logic signed [15:0] smp, logic [23:0] idx, logic start);
		int gap;
		gap = tx_idle ? $urandom_range(0, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {idx, smp};
		s_tuser <= start;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decimate_item(smp, idx, start);
		items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_X_BASE:  cfg.x_base = value[XB_W-1:0];
			REG_X_LIMIT: cfg.x_limit = value[XB_W-1:0];
			REG_X_RATIO: cfg.x_ratio = value[XR_W-1:0];
			REG_X_PHASE: cfg.x_phase = value[XP_W-1:0];
			REG_Y_BASE:  cfg.y_base = value[YB_W-1:0];
			REG_Y_GAIN:  cfg.y_gain = value[YG_W-1:0];
			default: ;
		endcase
	endtask

	// drop valid, wait for every point, then let items with no point leave the pipeline
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (points_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (points_due.size() != 0) begin
			note_mismatch($sformatf("%0d points never arrived", points_due.size()));
			points_due.delete();
		end
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic rand_config();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 0;
			1: v = 4095;
			2: v = $urandom;
			default: v = ($urandom & ~32'hFFF) | $urandom_range(0, 200);
		endcase
		write_reg(REG_X_BASE, v);
		case ($urandom_range(0, 4))
			0: v = 0;
			1: v = $urandom;
			2: v = $urandom;
			default: v = 4095;
		endcase
		write_reg(REG_X_LIMIT, v);
		case ($urandom_range(0, 5))
			0: v = 0;
			1: v = 32'hFFFF_FFFF;
			2: v = $urandom;
			default: v = $urandom_range(32'h800, 32'h3_0000);
		endcase
		write_reg(REG_X_RATIO, v);
		case ($urandom_range(0, 4))
			0: v = 32'h2_0000;
			1: v = 32'h1_FFFF;
			2: v = 0;
			default: v = $urandom;
		endcase
		write_reg(REG_X_PHASE, v);
		case ($urandom_range(0, 4))
			0: v = 32'h8000;
			1: v = 32'h7FFF;
			2: v = 0;
			default: v = $urandom;
		endcase
		write_reg(REG_Y_BASE, v);
		case ($urandom_range(0, 5))
			0: v = 0;
			1: v = 32'hFF_FFFF;
			2: v = 32'h1_0000;
			3: v = $urandom;
			default: v = $urandom_range(0, 32'h4_0000);
		endcase
		write_reg(REG_Y_GAIN, v);
	endtask

	// one block of indexes spaced by step, mostly opened by a block start
	task automatic run_sweep(int len, logic [23:0] first_idx, int step);
		logic [23:0] idx;
		logic signed [15:0] smp;
		idx = first_idx;
		smp = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 3))
				0: ;
				1: smp = smp + 16'($urandom_range(0, 64)) - 16'sd32;
				default: smp = 16'($urandom);
			endcase
			send_sample(smp, idx, i == 0 && $urandom_range(0, 9) != 0);
			idx = idx + 24'(step);
		end
	endtask

	task automatic test_directed_points();
		send_sample(16'sd0, 24'd0, 1'b1);
		send_sample(16'sd32767, 24'd0, 1'b0);
		send_sample(16'h8000, 24'd0, 1'b0);
		send_sample(16'sd5, 24'd1, 1'b0);
		send_sample(16'sd5, 24'd1, 1'b0);
		send_sample(-16'sd1, 24'd2, 1'b0);
		send_sample(16'sd100, 24'hFF_FFFF, 1'b1);
		send_sample(16'sd100, 24'd4094, 1'b0);
		settle();
	endtask

	task automatic test_right_limit();
		write_reg(REG_X_LIMIT, 32'd1);
		send_sample(16'sd7, 24'd0, 1'b1);
		send_sample(16'sd8, 24'd1, 1'b0);
		send_sample(16'sd9, 24'd2, 1'b0);
		send_sample(16'sd9, 24'd3, 1'b0);
		send_sample(16'sd9, 24'd0, 1'b0);
		send_sample(16'sd1, 24'd0, 1'b1);
		settle();
	endtask

	task automatic test_extreme_mapping();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		write_reg(REG_X_LIMIT, 32'd4095);
		write_reg(REG_X_BASE, 32'd100);
		write_reg(REG_X_RATIO, 32'hFFFF_FFFF);
		write_reg(REG_X_PHASE, 32'h0002_0000);
		write_reg(REG_Y_BASE, 32'h0000_8000);
		write_reg(REG_Y_GAIN, 32'h00FF_FFFF);
		send_sample(16'sd1, 24'd0, 1'b1);
		send_sample(16'h8000, 24'd1, 1'b0);
		send_sample(16'sd0, 24'd2, 1'b0);
		send_sample(16'sd0, 24'd3, 1'b0);
		settle();
	endtask

	task automatic test_random_sweeps();
		int target;
		logic [23:0] first_idx;
		int step;
		for (int p = 0; p < 10; p++) begin
			tx_idle = (p % 4 == 0) || (p % 4 == 2);
			rx_idle = (p % 4 == 0) || (p % 4 == 1);
			rand_config();
			target = items_sent + 80;
			while (items_sent < target) begin
				first_idx = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 300));
				step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 1;
				run_sweep($urandom_range(4, 40), first_idx, step);
			end
			settle();
		end
	endtask

	task automatic test_back_pressure();
		write_reg(REG_X_BASE, 32'd0);
		write_reg(REG_X_LIMIT, 32'd4095);
		write_reg(REG_X_RATIO, 32'h0001_0000);
		write_reg(REG_X_PHASE, 32'd0);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold = 400;
		run_sweep(60, 24'd0, 1);
		settle();
	endtask

	task automatic test_noise();
		logic [23:0] idx;
		for (int r = 0; r < 3; r++) begin
			tx_idle = r != 1;
			rx_idle = r != 2;
			rand_config();
			for (int i = 0; i < 50; i++) begin
				idx = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 300));
				send_sample(16'($urandom), idx, $urandom_range(0, 5) == 0);
			end
			settle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg = '{x_base: X_BASE_RST, x_limit: X_LIMIT_RST, x_ratio: X_RATIO_RST,
			x_phase: X_PHASE_RST, y_base: Y_BASE_RST, y_gain: Y_GAIN_RST};
		pend_valid = 1'b0;
		sweep_stopped = 1'b0;
		pend_col = '0;
		col_min = '0;
		col_max = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_points();
		test_right_limit();
		test_extreme_mapping();
		test_random_sweeps();
		test_back_pressure();
		test_noise();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
